FILE: rtl/edr_pkg.sv
// Shared types, constants and lookup functions of the ECU diagnostic responder.
// Used by edr_front, edr_queue, edr_back and ecu_diagnostic_responder.
package edr_pkg;

  localparam int BufferDepth = 6;
  localparam int CountW      = $clog2(BufferDepth + 1);
  localparam int IdxW        = $clog2(BufferDepth);
  localparam int NumStatic   = 5;
  localparam int ReadLen     = 4;
  localparam int NumRegs     = 4;
  localparam int RegW        = 64;
  localparam int AddrW       = 5;
  localparam int QueueDepth  = 4;
  localparam int QPtrW       = $clog2(QueueDepth);
  localparam int QCountW     = $clog2(QueueDepth + 1);
  localparam int EchoW       = 5;
  localparam int PosW        = 5;

  localparam logic [7:0] ReadSvc    = 8'h21;
  localparam logic [7:0] ReadAck    = 8'h61;
  localparam logic [7:0] ReqLenByte = 8'h02;
  localparam logic [7:0] CksumBase  = 8'h23;
  localparam logic [7:0] IdAll      = 8'h00;
  localparam logic [7:0] IdShort    = 8'h06;

  // Reply kinds: the five fixed commands first, in match priority order.
  typedef enum logic [2:0] {
    KIND_START,
    KIND_SESSION,
    KIND_SEED,
    KIND_KEY,
    KIND_HEARTBEAT,
    KIND_READ_WORD,
    KIND_READ_10,
    KIND_READ_20
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  id;
    logic [15:0] value;
  } desc_t;

  typedef logic [NumRegs-1:0][RegW-1:0] sensor_regs_t;

  // Fixed command bytes, first byte in the lowest slot.
  function automatic logic [5:0][7:0] static_cmd(input kind_e kind);
    logic [5:0][7:0] c;
    case (kind)
      KIND_START:     c = {8'h0C, 8'h81, 8'hF7, 8'h13, 8'h81, 8'h00};
      KIND_SESSION:   c = {8'h00, 8'h00, 8'hB2, 8'hA0, 8'h10, 8'h02};
      KIND_SEED:      c = {8'h00, 8'h00, 8'h2A, 8'h01, 8'h27, 8'h02};
      KIND_KEY:       c = {8'h3A, 8'h34, 8'hD9, 8'h02, 8'h27, 8'h04};
      KIND_HEARTBEAT: c = {8'h00, 8'h00, 8'h41, 8'h01, 8'h3E, 8'h02};
      default:        c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] static_cmd_len(input kind_e kind);
    logic [2:0] n;
    case (kind)
      KIND_START: n = 3'd6;
      KIND_KEY:   n = 3'd6;
      default:    n = 3'd4;
    endcase
    return n;
  endfunction

  function automatic logic [5:0][7:0] static_rep(input kind_e kind);
    logic [5:0][7:0] r;
    case (kind)
      KIND_START:     r = {8'h00, 8'h28, 8'h8F, 8'hD5, 8'hC1, 8'h03};
      KIND_SESSION:   r = {8'h00, 8'h00, 8'h00, 8'h51, 8'h50, 8'h01};
      KIND_SEED:      r = {8'hA6, 8'hA4, 8'h96, 8'h01, 8'h67, 8'h04};
      KIND_KEY:       r = {8'h00, 8'h00, 8'h6B, 8'h02, 8'h67, 8'h02};
      KIND_HEARTBEAT: r = {8'h00, 8'h00, 8'h00, 8'h7F, 8'h7E, 8'h01};
      default:        r = '0;
    endcase
    return r;
  endfunction

  // Total reply length in bytes; also the echo length to drop.
  function automatic logic [PosW-1:0] reply_len(input kind_e kind);
    logic [PosW-1:0] n;
    case (kind)
      KIND_START:     n = 5'd5;
      KIND_SESSION:   n = 5'd3;
      KIND_SEED:      n = 5'd6;
      KIND_KEY:       n = 5'd4;
      KIND_HEARTBEAT: n = 5'd3;
      KIND_READ_WORD: n = 5'd6;
      KIND_READ_10:   n = 5'd14;
      KIND_READ_20:   n = 5'd24;
      default:        n = 5'd0;
    endcase
    return n;
  endfunction

  // Two-byte sensor ids: bit 4 flags a hit, bits 3..0 give the value slot.
  function automatic logic [4:0] slot_lookup(input logic [7:0] id);
    logic [4:0] s;
    case (id)
      8'h01:   s = {1'b1, 4'd0};
      8'h03:   s = {1'b1, 4'd1};
      8'h07:   s = {1'b1, 4'd2};
      8'h08:   s = {1'b1, 4'd3};
      8'h09:   s = {1'b1, 4'd4};
      8'h0A:   s = {1'b1, 4'd5};
      8'h0B:   s = {1'b1, 4'd6};
      8'h0C:   s = {1'b1, 4'd7};
      8'h0F:   s = {1'b1, 4'd8};
      8'h10:   s = {1'b1, 4'd9};
      8'h11:   s = {1'b1, 4'd10};
      8'h12:   s = {1'b1, 4'd11};
      8'h13:   s = {1'b1, 4'd12};
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

FILE: rtl/edr_front.sv
// Front end: receive buffer, echo drop and command matching.
// Depends on edr_pkg; pushes one reply descriptor per matched command.
module edr_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic [7:0]            rx_byte_i,
  input  edr_pkg::sensor_regs_t sensor_i,
  output logic                  push_o,
  output edr_pkg::desc_t        desc_o
);
  import edr_pkg::*;

  logic [7:0]        buf_q [BufferDepth];
  logic [CountW-1:0] count_q, count_d;
  logic [EchoW-1:0]  echo_q, echo_d;

  logic [7:0]        view [BufferDepth];
  logic [CountW-1:0] count_new;
  logic              take;
  logic              static_hit;
  kind_e             static_kind;
  logic              read_hit;
  kind_e             read_kind;
  logic [4:0]        slot;
  logic [15:0]       value;
  logic [RegW-1:0]   reg_word;

  assign take      = accept_i && (echo_q == '0) && (count_q < CountW'(BufferDepth));
  assign count_new = count_q + CountW'(1);

  // Buffer as it stands once the new byte is appended.
  always_comb begin
    for (int i = 0; i < BufferDepth; i++) begin
      view[i] = (CountW'(i) == count_q) ? rx_byte_i : buf_q[i];
    end
  end

  // Fixed commands; the earliest in the list wins.
  always_comb begin
    logic [5:0][7:0] cmd;
    logic [2:0]      len;
    logic            eq;
    static_hit  = 1'b0;
    static_kind = KIND_START;
    for (int k = NumStatic - 1; k >= 0; k--) begin
      cmd = static_cmd(kind_e'(3'(k)));
      len = static_cmd_len(kind_e'(3'(k)));
      eq  = (count_new >= CountW'(len));
      for (int j = 0; j < 6; j++) begin
        if ((3'(j) < len) && (view[j] != cmd[j])) eq = 1'b0;
      end
      if (eq) begin
        static_hit  = 1'b1;
        static_kind = kind_e'(3'(k));
      end
    end
  end

  // Sensor read request: 02 21 id checksum.
  assign slot = slot_lookup(view[2]);

  always_comb begin
    read_kind = KIND_READ_WORD;
    if (view[2] == IdAll) begin
      read_kind = KIND_READ_20;
    end else if (view[2] == IdShort) begin
      read_kind = KIND_READ_10;
    end
    read_hit = (count_new >= CountW'(ReadLen)) && (view[0] == ReqLenByte)
            && (view[1] == ReadSvc) && (view[3] == CksumBase + view[2])
            && ((view[2] == IdAll) || (view[2] == IdShort) || slot[4]);
  end

  assign reg_word = sensor_i[slot[3:2]];

  always_comb begin
    case (slot[1:0])
      2'd0:    value = reg_word[15:0];
      2'd1:    value = reg_word[31:16];
      2'd2:    value = reg_word[47:32];
      default: value = reg_word[63:48];
    endcase
  end

  always_comb begin
    push_o       = take && (static_hit || read_hit);
    desc_o.kind  = static_hit ? static_kind : read_kind;
    desc_o.id    = view[2];
    desc_o.value = value;
  end

  // Count and echo bookkeeping; a match always leaves the buffer empty.
  always_comb begin
    count_d = count_q;
    echo_d  = echo_q;
    if (accept_i) begin
      if (echo_q != '0) begin
        echo_d = echo_q - EchoW'(1);
      end else if (take) begin
        if (push_o) begin
          count_d = '0;
          echo_d  = EchoW'(reply_len(desc_o.kind));
        end else begin
          count_d = count_new;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      echo_q  <= '0;
    end else begin
      count_q <= count_d;
      echo_q  <= echo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      buf_q[count_q[IdxW-1:0]] <= rx_byte_i;
    end
  end

endmodule

FILE: rtl/edr_queue.sv
// Short descriptor queue between the front and back ends.
// Depends on edr_pkg for the descriptor type and depth.
module edr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  edr_pkg::desc_t desc_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           empty_o,
  output edr_pkg::desc_t head_o
);
  import edr_pkg::*;

  desc_t              mem_q [QueueDepth];
  logic [QPtrW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [QCountW-1:0] cnt_q, cnt_d;
  logic               do_push, do_pop;

  assign full_o  = (cnt_q == QCountW'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = do_push ? wr_q + QPtrW'(1) : wr_q;
    rd_d  = do_pop ? rd_q + QPtrW'(1) : rd_q;
    cnt_d = cnt_q + QCountW'(do_push) - QCountW'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= desc_i;
    end
  end

endmodule

FILE: rtl/edr_back.sv
// Back end: expands the descriptor at the queue head into reply bytes.
// Depends on edr_pkg; drives the registered output stream.
module edr_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           empty_i,
  input  edr_pkg::desc_t head_i,
  output logic           pop_o,
  output logic           m_axis_tvalid_o,
  input  logic           m_axis_tready_i,
  output logic [7:0]     m_axis_tdata_o,
  output logic           m_axis_tlast_o
);
  import edr_pkg::*;

  logic [PosW-1:0] pos_q, pos_d;
  logic [7:0]      sum_q, sum_d;
  logic            valid_q, valid_d;
  logic [7:0]      data_q, data_d;
  logic            last_q, last_d;

  logic            advance, emit, is_last;
  logic [PosW-1:0] len;
  logic [5:0][7:0] rep;
  logic [7:0]      byte_v;

  assign advance = !valid_q || m_axis_tready_i;
  assign emit    = advance && !empty_i;
  assign len     = reply_len(head_i.kind);
  assign is_last = (pos_q == len - PosW'(1));
  assign rep     = static_rep(head_i.kind);
  assign pop_o   = emit && is_last;

  always_comb begin
    byte_v = 8'h00;
    case (head_i.kind)
      KIND_READ_WORD, KIND_READ_10, KIND_READ_20: begin
        if (is_last) begin
          byte_v = sum_q;
        end else begin
          case (pos_q)
            5'd0:    byte_v = 8'(len) - 8'd3;
            5'd1:    byte_v = ReadAck;
            5'd2:    byte_v = head_i.id;
            5'd3:    byte_v = (head_i.kind == KIND_READ_WORD) ? head_i.value[15:8] : 8'h00;
            5'd4:    byte_v = (head_i.kind == KIND_READ_WORD) ? head_i.value[7:0] : 8'h00;
            default: byte_v = 8'h00;
          endcase
        end
      end
      default: byte_v = rep[pos_q[2:0]];
    endcase
  end

  always_comb begin
    pos_d   = pos_q;
    sum_d   = sum_q;
    valid_d = valid_q;
    data_d  = data_q;
    last_d  = last_q;
    if (advance) begin
      valid_d = emit;
      if (emit) begin
        data_d = byte_v;
        last_d = is_last;
        pos_d  = is_last ? '0 : pos_q + PosW'(1);
        sum_d  = is_last ? 8'h00 : sum_q + byte_v;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      sum_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      sum_q   <= sum_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    last_q <= last_d;
  end

  assign m_axis_tvalid_o = valid_q;
  assign m_axis_tdata_o  = data_q;
  assign m_axis_tlast_o  = last_q;

endmodule

FILE: rtl/ecu_diagnostic_responder.sv
// Top level of the ECU diagnostic responder: config registers and wiring.
// Depends on edr_pkg, edr_front, edr_queue and edr_back.
//
// Usage:
//   s_axis carries received serial bytes (tdata = rx_byte). Back-to-back
//   transfers are accepted at one per cycle while the reply queue is not full.
//   m_axis carries reply bytes (tdata = tx_byte, tlast on the final byte).
//   The front end matches a command on the byte that completes it and queues
//   a reply descriptor in the same cycle; the first reply byte then passes
//   from the queue through the output register onto m_axis. The back end then
//   drives one reply byte per cycle (3 to 24 bytes per reply) while tready is high.
//   When the receiver stalls, the output register holds its byte and the
//   queue (four replies deep) absorbs new matches; s_axis_tready_o drops only
//   while that queue is full. Echo drop and full-buffer drop go on as usual.
//   Sensor values sit in four 64-bit APB registers at byte addresses 0, 8,
//   16 and 24; write them only while no reply is pending. pready is always high.
//   Reset clears the buffer count, echo counter, queue, output valid and the
//   sensor registers. No clearing pass is needed.
module ecu_diagnostic_responder (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // APB configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [edr_pkg::AddrW-1:0]  paddr,
  input  logic [edr_pkg::RegW-1:0]   pwdata,
  output logic [edr_pkg::RegW-1:0]   prdata,
  output logic                       pready,
  // input stream
  input  logic                       s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  input  logic [7:0]                 s_axis_tdata_i,   // [7:0] rx_byte
  // output stream
  output logic                       m_axis_tvalid_o,
  input  logic                       m_axis_tready_i,
  output logic [7:0]                 m_axis_tdata_o,   // [7:0] tx_byte
  output logic                       m_axis_tlast_o    // last
);
  import edr_pkg::*;

  sensor_regs_t sensor_q;
  logic         cfg_wr;
  logic         accept;
  logic         push;
  desc_t        desc;
  logic         full;
  logic         empty;
  desc_t        head;
  logic         pop;

  // Register index sits above the 8-byte offset bits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = sensor_q[paddr[AddrW-1:3]];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sensor_q <= '0;
    end else if (cfg_wr) begin
      sensor_q[paddr[AddrW-1:3]] <= pwdata;
    end
  end

  // Accept whenever the queue can take a possible match.
  assign s_axis_tready_o = !full;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  edr_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .rx_byte_i (s_axis_tdata_i),
    .sensor_i  (sensor_q),
    .push_o    (push),
    .desc_o    (desc)
  );

  edr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .desc_i  (desc),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  edr_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head),
    .pop_o           (pop),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

FILE: sim/ecu_diagnostic_responder_tb.sv
// Self-checking testbench of ecu_diagnostic_responder: stream driver, reply monitor,
// APB register setup and a byte-by-byte reply predictor.
// Depends on edr_pkg and the ecu_diagnostic_responder RTL.
module ecu_diagnostic_responder_tb;
  import edr_pkg::*;

  localparam int IdleLimit = 5000;   // cycles with no transfer before giving up
  localparam int LongStall = 600;    // receiver hold-off that fills the reply queue
  // two-byte sensor ids, value slot 0 first
  localparam logic [103:0] WordIds = 104'h01_03_07_08_09_0A_0B_0C_0F_10_11_12_13;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } reply_beat_t;

  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [AddrW-1:0]  paddr   = '0;
  logic [RegW-1:0]   pwdata  = '0;
  logic [RegW-1:0]   prdata;
  logic              pready;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [7:0]        s_tdata  = '0;   // [7:0] rx_byte
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [7:0]        m_tdata;         // [7:0] tx_byte
  logic              m_tlast;

  ecu_diagnostic_responder u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Line bytes waiting to be sent, and reply bytes the block still owes.
  logic [7:0]  rx_pending[$];
  reply_beat_t tx_expected[$];

  // Shadow of the block: receive buffer, echo counter and sensor registers.
  logic [7:0]     shadow_buf[$];
  int             shadow_echo = 0;
  logic [RegW-1:0] shadow_sensor[NumRegs];

  int  mismatches   = 0;
  int  rx_accepted  = 0;
  int  tx_checked   = 0;
  int  replies_seen = 0;
  int  cmd_bytes    = 0;
  bit  src_idle_on  = 1'b0;
  bit  snk_idle_on  = 1'b0;
  int  stall_req    = 0;

  // Append one byte to the line queue.
  function automatic void line_put(input logic [7:0] b);
    rx_pending = {rx_pending, b};
  endfunction

  // Fixed commands and replies, first byte in the top bits.
  function automatic logic [47:0] fixed_cmd(input kind_e k);
    case (k)
      KIND_START:     return 48'h00_81_13_F7_81_0C;
      KIND_SESSION:   return 48'h02_10_A0_B2_00_00;
      KIND_SEED:      return 48'h02_27_01_2A_00_00;
      KIND_KEY:       return 48'h04_27_02_D9_34_3A;
      KIND_HEARTBEAT: return 48'h02_3E_01_41_00_00;
      default:        return '0;
    endcase
  endfunction

  function automatic int fixed_cmd_len(input kind_e k);
    return (k == KIND_START || k == KIND_KEY) ? 6 : 4;
  endfunction

  function automatic logic [47:0] fixed_reply(input kind_e k);
    case (k)
      KIND_START:     return 48'h03_C1_D5_8F_28_00;
      KIND_SESSION:   return 48'h01_50_51_00_00_00;
      KIND_SEED:      return 48'h04_67_01_96_A4_A6;
      KIND_KEY:       return 48'h02_67_02_6B_00_00;
      KIND_HEARTBEAT: return 48'h01_7E_7F_00_00_00;
      default:        return '0;
    endcase
  endfunction

  function automatic int fixed_reply_len(input kind_e k);
    case (k)
      KIND_START: return 5;
      KIND_SEED:  return 6;
      KIND_KEY:   return 4;
      default:    return 3;
    endcase
  endfunction

  // Value slot of a two-byte id, -1 when the id has none.
  function automatic int word_slot(input logic [7:0] id);
    int k;
    for (k = 0; k < 13; k++) begin
      if (WordIds[103-8*k -: 8] == id) return k;
    end
    return -1;
  endfunction

  // Advance the shadow by one accepted line byte and queue the reply it causes.
  function automatic void answer_byte(input logic [7:0] b);
    logic [7:0]  rep[$];
    logic [47:0] pat;
    logic [7:0]  id;
    logic [7:0]  sum;
    logic [15:0] v;
    kind_e       kd;
    reply_beat_t beat;
    int          k, j, n, dlen, slot;
    bit          hit, ok;
    if (shadow_echo > 0) begin
      shadow_echo--;
      return;
    end
    if (shadow_buf.size() >= BufferDepth) return;
    shadow_buf = {shadow_buf, b};
    hit = 1'b0;
    // fixed commands first, in priority order
    for (k = 0; k < NumStatic; k++) begin
      kd  = kind_e'(k);
      n   = fixed_cmd_len(kd);
      pat = fixed_cmd(kd);
      if (!hit && shadow_buf.size() >= n) begin
        ok = 1'b1;
        for (j = 0; j < n; j++) begin
          if (shadow_buf[j] != pat[47-8*j -: 8]) ok = 1'b0;
        end
        if (ok) begin
          hit = 1'b1;
          repeat (n) void'(shadow_buf.pop_front());
          pat = fixed_reply(kd);
          for (j = 0; j < fixed_reply_len(kd); j++) rep = {rep, pat[47-8*j -: 8]};
        end
      end
    end
    // sensor read: 02 21 id checksum
    if (!hit && shadow_buf.size() >= ReadLen && shadow_buf[0] == ReqLenByte &&
        shadow_buf[1] == ReadSvc) begin
      id = shadow_buf[2];
      if (shadow_buf[3] == 8'(CksumBase + id)) begin
        dlen = 0;
        slot = -1;
        if (id == IdAll) dlen = 20;
        else if (id == IdShort) dlen = 10;
        else begin
          slot = word_slot(id);
          if (slot >= 0) dlen = 2;
        end
        if (dlen > 0) begin
          hit = 1'b1;
          repeat (ReadLen) void'(shadow_buf.pop_front());
          rep = {rep, 8'(dlen + 1)};
          rep = {rep, ReadAck};
          rep = {rep, id};
          if (dlen == 2) begin
            v = shadow_sensor[slot / 4][16 * (slot % 4) +: 16];
            rep = {rep, v[15:8]};
            rep = {rep, v[7:0]};
          end else begin
            repeat (dlen) rep = {rep, 8'h00};
          end
          sum = 8'h00;
          foreach (rep[j]) sum = sum + rep[j];
          rep = {rep, sum};
        end
      end
    end
    if (hit) begin
      foreach (rep[j]) begin
        beat.data   = rep[j];
        beat.last   = (j == rep.size() - 1);
        tx_expected = {tx_expected, beat};
      end
      shadow_echo = rep.size();
    end
  endfunction

  // Sender: bursts of random length with random gaps; holds a byte until taken.
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata  <= '0;
    end else begin
      if (s_tvalid && s_tready) begin
        answer_byte(s_tdata);
        rx_accepted++;
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (rx_pending.size() > 0) begin
          s_tvalid <= 1'b1;
          s_tdata  <= rx_pending.pop_front();
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 15);
            gap_left   = (src_idle_on && $urandom_range(0, 3) != 0) ? $urandom_range(1, 12) : 0;
          end
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: stall mask redrawn whenever its age counter runs out, plus one long hold-off on request.
  int          stall_seen = 0;
  int          stall_left = 0;
  int          mask_age   = 0;
  logic [15:0] stall_mask = '1;
  reply_beat_t want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        tx_checked++;
        if (tx_expected.size() == 0) begin
          $error("tx_byte 0x%02h arrived with no reply byte pending", m_tdata);
          mismatches++;
        end else begin
          want = tx_expected.pop_front();
          if (m_tdata !== want.data) begin
            $error("tx_byte: expected 0x%02h, got 0x%02h", want.data, m_tdata);
            mismatches++;
          end
          if (m_tlast !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_tlast);
            mismatches++;
          end
          if (want.last) replies_seen++;
        end
      end
      if (stall_req != stall_seen && m_tvalid) begin
        stall_seen = stall_req;
        stall_left = LongStall;
      end
      if (mask_age == 0) begin
        stall_mask = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
        mask_age   = 63;
      end else begin
        mask_age--;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else if (!snk_idle_on) begin
        m_tready <= 1'b1;
      end else begin
        m_tready <= stall_mask[mask_age % 16];
      end
    end
  end

  // Watchdog: count cycles with no transfer on either stream.
  int idle_cycles = 0;

  always @(posedge clk_i) begin
    if (!rst_ni || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IdleLimit) begin
        $display("watchdog: no transfer for %0d cycles, %0d reply bytes outstanding",
                 idle_cycles, tx_expected.size());
        $display("FAIL ecu_diagnostic_responder");
        $finish;
      end
    end
  end

  task automatic apb_write(input int idx, input logic [RegW-1:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= AddrW'(idx * 8);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    shadow_sensor[idx] = value;
  endtask

  task automatic apb_readback(input int idx);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= AddrW'(idx * 8);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== shadow_sensor[idx]) begin
      $error("sensor_values_%0d: expected 0x%016h, got 0x%016h", idx,
             shadow_sensor[idx], prdata);
      mismatches++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // mode 0: random, 1: all ones, 2: all zeros
  task automatic load_sensors(input int mode);
    logic [RegW-1:0] val;
    int i;
    for (i = 0; i < NumRegs; i++) begin
      case (mode)
        1:       val = '1;
        2:       val = '0;
        default: val = {$urandom, $urandom};
      endcase
      apb_write(i, val);
      apb_readback(i);
    end
  endtask

  // fill < 0 gives random echo bytes
  task automatic queue_echo(input int n, input int fill);
    repeat (n) line_put(fill < 0 ? 8'($urandom_range(0, 255)) : 8'(fill));
  endtask

  task automatic queue_fixed(input kind_e k, input int fill);
    logic [47:0] pat;
    int j;
    pat = fixed_cmd(k);
    for (j = 0; j < fixed_cmd_len(k); j++) line_put(pat[47-8*j -: 8]);
    cmd_bytes += fixed_cmd_len(k);
    queue_echo(fixed_reply_len(k), fill);
  endtask

  task automatic queue_read(input logic [7:0] id);
    line_put(ReqLenByte);
    line_put(ReadSvc);
    line_put(id);
    line_put(8'(CksumBase + id));
    cmd_bytes += ReadLen;
    queue_echo(id == IdAll ? 24 : (id == IdShort ? 14 : 6), -1);
  endtask

  function automatic logic [7:0] pick_read_id();
    int r;
    r = $urandom_range(0, 14);
    if (r == 13) return IdAll;
    if (r == 14) return IdShort;
    return WordIds[103-8*r -: 8];
  endfunction

  // Random well-formed dialogue: fixed commands and sensor reads, each with its echo.
  task automatic queue_dialogue(input int nbytes);
    int stop;
    stop = cmd_bytes + nbytes;
    while (cmd_bytes < stop) begin
      if ($urandom_range(0, 9) < 4) queue_fixed(kind_e'($urandom_range(0, NumStatic - 1)), -1);
      else queue_read(pick_read_id());
    end
  endtask

  // Let the sender run dry and collect every reply before returning.
  task automatic drain();
    while (rx_pending.size() > 0 || s_tvalid || tx_expected.size() > 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0] id;
    int i;
    foreach (shadow_sensor[i]) shadow_sensor[i] = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: every fixed command, echo bytes at both extremes, first and
    // last word slot, and both long zero-filled reads (the 24-byte reply too).
    load_sensors(0);
    queue_fixed(KIND_START, 8'h00);
    queue_fixed(KIND_SESSION, 8'hFF);
    queue_fixed(KIND_SEED, -1);
    queue_fixed(KIND_KEY, -1);
    queue_fixed(KIND_HEARTBEAT, -1);
    queue_read(8'h01);
    queue_read(8'h13);
    queue_read(IdShort);
    queue_read(IdAll);
    drain();

    // Random dialogue, all-ones sensors, both sides idling.
    load_sensors(1);
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    queue_dialogue(6);
    drain();

    // All-zero sensors; receiver holds off long enough to fill the reply queue.
    load_sensors(2);
    stall_req++;
    queue_dialogue(20);
    drain();

    // Random sensors, back-to-back transfers with no idling.
    load_sensors(0);
    src_idle_on = 1'b0;
    snk_idle_on = 1'b0;
    queue_dialogue(6);
    drain();

    load_sensors(0);
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
    queue_dialogue(6);
    drain();

    // Broken read request: unknown id or bad checksum. The buffer never
    // clears, fills up, and every later byte is dropped with no reply.
    if ($urandom_range(0, 1) == 0) begin
      do id = 8'($urandom_range(0, 255));
      while (id == IdAll || id == IdShort || word_slot(id) >= 0);
      line_put(ReqLenByte);
      line_put(ReadSvc);
      line_put(id);
      line_put(8'(CksumBase + id));
    end else begin
      id = pick_read_id();
      line_put(ReqLenByte);
      line_put(ReadSvc);
      line_put(id);
      line_put(8'(CksumBase + id + 8'($urandom_range(1, 255))));
    end
    queue_fixed(KIND_HEARTBEAT, -1);
    queue_echo(4, -1);
    drain();
    repeat (24) @(posedge clk_i);

    $display("Run covered %0d line bytes (%0d in commands), %0d replies, %0d reply bytes.",
             rx_accepted, cmd_bytes, replies_seen, tx_checked);
    $display("Covered: extreme and random sensor values, idling, long stall, stuck buffer.");
    if (mismatches == 0 && tx_expected.size() == 0) begin
      $display("PASS ecu_diagnostic_responder");
    end else begin
      $display("FAIL ecu_diagnostic_responder");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/edr_pkg.sv
rtl/edr_front.sv
rtl/edr_queue.sv
rtl/edr_back.sv
rtl/ecu_diagnostic_responder.sv
sim/ecu_diagnostic_responder_tb.sv
